>>> sv/pec_pkg.sv
// Shared types, constants and codes for the partition entry checker.
package pec_pkg;

	localparam int LBA_W           = 64;
	localparam int GUID_HALF_W     = 64;
	localparam int ATTR_W          = 64;
	localparam int IDX_W           = 7;
	localparam int OP_W            = 2;
	localparam int ATTR_OS_BIT     = 1;
	localparam int MAX_ENTRIES_DEF = 128;
	localparam int APB_AW          = 4;
	localparam int APB_DW          = 64;
	localparam logic [LBA_W-1:0] FIRST_LBA_RST = LBA_W'(34);
	localparam logic [LBA_W-1:0] LAST_LBA_RST  = '0;

	// Register select, taken from paddr bit 3
	typedef enum logic {
		REG_FIRST_LBA = 1'b0,
		REG_LAST_LBA  = 1'b1
	} pec_reg_t;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} pec_op_t;

	// Per-entry status flags
	typedef struct packed {
		logic used;
		logic oor;
		logic ovl;
		logic os;
	} pec_flags_t;

	// Token that walks down the cell chain, one cell per cycle
	typedef struct packed {
		logic             vld;
		pec_op_t          op;
		logic [LBA_W-1:0] entry_start;
		logic [LBA_W-1:0] end_lba;
		pec_flags_t       fl;
		logic             placed;
		logic [IDX_W-1:0] idx;
	} pec_tok_t;

	// One result item
	typedef struct packed {
		logic [IDX_W-1:0] entry_index;
		pec_flags_t       fl;
		logic             usable;
		logic             table_full;
	} pec_res_t;

endpackage

>>> sv/pec_req_if.sv
// Request channel: one operation per transfer.
interface pec_req_if import pec_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [OP_W-1:0]        operation;
	logic [GUID_HALF_W-1:0] type_guid_high;
	logic [GUID_HALF_W-1:0] type_guid_low;
	logic [LBA_W-1:0]       entry_start;
	logic [LBA_W-1:0]       end_lba;
	logic [ATTR_W-1:0]      attribute_bits;
	logic [IDX_W-1:0]       query_index;

	modport source (
		output valid, operation, type_guid_high, type_guid_low,
		output entry_start, end_lba, attribute_bits, query_index,
		input  ready
	);
	modport sink (
		input  valid, operation, type_guid_high, type_guid_low,
		input  entry_start, end_lba, attribute_bits, query_index,
		output ready
	);
endinterface

>>> sv/pec_rsp_if.sv
// Response channel: one status result per transfer.
interface pec_rsp_if import pec_pkg::*;;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] entry_index;
	logic             entry_used;
	logic             bounds_bad;
	logic             overlap;
	logic             os_reserved;
	logic             usable;
	logic             table_full;

	modport source (
		output valid, entry_index, entry_used, bounds_bad, overlap,
		output os_reserved, usable, table_full,
		input  ready
	);
	modport sink (
		input  valid, entry_index, entry_used, bounds_bad, overlap,
		input  os_reserved, usable, table_full,
		output ready
	);
endinterface

>>> sv/partition_entry_checker.sv
// Top level: request launch, cell chain, result staging and APB registers.
//
//   channel | dir | handshake           | payload
//   req     | in  | valid/ready         | operation, type GUID, LBA range, attributes, index
//   rsp     | out | valid/ready         | entry_index and status flags
//   apb     | in  | psel/penable/pready | usable window low (0x0), usable window high (0x8)
//
// Every operation sends one token down a chain of MAX_ENTRIES cells, one cell per cycle,
// so a request passes the launch register, each cell's hand-off register and the staging register.
// One request is in flight at a time; the next is taken while the last result waits
// in the output register. A stalled response holds the staged result and the chain idle.
// Reset clears all slot flags and occupancy; no clearing pass is needed.
module partition_entry_checker import pec_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	pec_req_if.sink           req,
	pec_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	logic [LBA_W-1:0]       first_lba;
	logic [LBA_W-1:0]       last_lba;
	pec_tok_t               tok_s0;
	pec_tok_t               launch;
	pec_tok_t               chain [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] tok_vld_vec;
	pec_tok_t               tok_exit;
	pec_res_t               res;
	pec_res_t               pend_q;
	pec_res_t               out_q;
	logic                   pend_vld_q;
	logic                   out_vld_q;
	logic                   busy_q;
	logic                   acc;
	logic                   move;
	logic                   used;
	logic                   oor;
	logic [CNT_W-1:0]       fill_q;
	logic                   tbl_full;
	logic                   ld_used;

	pec_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.first_lba (first_lba),
		.last_lba  (last_lba)
	);

	assign req.ready = !busy_q;
	assign acc       = req.valid && !busy_q;

	// Occupied-slot count, tracked at transfer
	assign tbl_full = (fill_q == CNT_W'(MAX_ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (acc) begin
			case (pec_op_t'(req.operation))
				OP_CLEAR: fill_q <= '0;
				OP_LOAD:  fill_q <= tbl_full ? fill_q : fill_q + CNT_W'(1);
				default:  fill_q <= fill_q;
			endcase
		end
	end

	// Classify the new entry on transfer; a load into a full table is inert
	assign used    = (|req.type_guid_high) || (|req.type_guid_low);
	assign ld_used = used && !tbl_full;
	assign oor  = (req.entry_start > req.end_lba) ||
		(req.entry_start < first_lba) || (req.entry_start > last_lba) ||
		(req.end_lba < first_lba) || (req.end_lba > last_lba);

	always_comb begin
		launch             = '0;
		launch.vld         = acc;
		launch.op          = pec_op_t'(req.operation);
		launch.entry_start = req.entry_start;
		launch.end_lba     = req.end_lba;
		case (pec_op_t'(req.operation))
			OP_LOAD: begin
				launch.fl.used = ld_used;
				launch.fl.oor  = ld_used && oor;
				launch.fl.os   = ld_used && !oor && req.attribute_bits[ATTR_OS_BIT];
			end
			OP_QUERY: begin
				launch.idx = req.query_index;
			end
			default: begin
				launch.idx = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s0 <= '0;
		end else begin
			tok_s0 <= launch;
		end
	end

	// Cell chain
	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		if (g == 0) begin : g_head
			pec_cell #(.INDEX(g)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.tok_in  (tok_s0),
				.tok_out (chain[g])
			);
		end else begin : g_body
			pec_cell #(.INDEX(g)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.tok_in  (chain[g-1]),
				.tok_out (chain[g])
			);
		end
		assign tok_vld_vec[g] = chain[g].vld;
	end

	assign tok_exit = chain[MAX_ENTRIES-1];

	// Turn the exiting token into a result
	always_comb begin
		res = '0;
		case (tok_exit.op)
			OP_LOAD: begin
				if (tok_exit.placed) begin
					res.entry_index = tok_exit.idx;
					res.fl          = tok_exit.fl;
				end else begin
					res.table_full  = 1'b1;
				end
			end
			OP_QUERY: begin
				res.entry_index = tok_exit.idx;
				res.fl          = tok_exit.fl;
			end
			default: begin
				res.table_full = 1'b0;
			end
		endcase
		res.usable = res.fl.used && !res.fl.oor && !res.fl.ovl && !res.fl.os;
	end

	assign move = pend_vld_q && (!out_vld_q || rsp.ready);

	// Busy until the result reaches the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (acc) begin
				busy_q <= 1'b1;
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (tok_exit.vld) begin
				pend_vld_q <= 1'b1;
			end else if (move) begin
				pend_vld_q <= 1'b0;
			end
			if (move) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_exit.vld) begin
			pend_q <= res;
		end
		if (move) begin
			out_q <= pend_q;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.entry_index = out_q.entry_index;
	assign rsp.entry_used  = out_q.fl.used;
	assign rsp.bounds_bad  = out_q.fl.oor;
	assign rsp.overlap     = out_q.fl.ovl;
	assign rsp.os_reserved = out_q.fl.os;
	assign rsp.usable      = out_q.usable;
	assign rsp.table_full  = out_q.table_full;

	// Never more than one token in the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vld_vec) <= 1)
		else $error("more than one token in cell chain");

	// No transfer while a token is still walking
	a_no_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> !(|tok_vld_vec) && !tok_s0.vld && !pend_vld_q)
		else $error("request taken while chain busy");

	// Exiting token always finds the staging register free
	a_pend_free: assert property (@(posedge clk) disable iff (!arst_n)
		tok_exit.vld |-> !pend_vld_q)
		else $error("result staging overrun");

	// A full-table result carries no other status
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.table_full) |-> !rsp.entry_used && !rsp.usable &&
		(rsp.entry_index == '0))
		else $error("table_full result with status bits");

	// Flags only on used entries
	a_flags_used: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.bounds_bad || rsp.overlap || rsp.os_reserved || rsp.usable))
		|-> rsp.entry_used)
		else $error("status flag on unused entry");

endmodule

>>> sv/pec_cfg.sv
// APB register block holding the usable LBA window.
module pec_cfg import pec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [LBA_W-1:0]  first_lba,
	output logic [LBA_W-1:0]  last_lba
);

	logic [LBA_W-1:0] first_q;
	logic [LBA_W-1:0] last_q;
	logic             wr_en;
	pec_reg_t         sel;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign sel    = pec_reg_t'(paddr[3]);

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= FIRST_LBA_RST;
			last_q  <= LAST_LBA_RST;
		end else if (wr_en) begin
			case (sel)
				REG_FIRST_LBA: first_q <= pwdata;
				REG_LAST_LBA:  last_q  <= pwdata;
				default:       first_q <= first_q;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (sel)
			REG_FIRST_LBA: prdata = first_q;
			REG_LAST_LBA:  prdata = last_q;
			default:       prdata = '0;
		endcase
	end

	assign first_lba = first_q;
	assign last_lba  = last_q;

endmodule

>>> sv/pec_cell.sv
// One table slot: stores an entry and processes the token passing by.
module pec_cell import pec_pkg::*; #(
	parameter int INDEX = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  pec_tok_t tok_in,
	output pec_tok_t tok_out
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
	localparam bit               QRY_OK = (INDEX < (2 ** IDX_W));

	logic             occ_q;
	pec_flags_t       flags_q;
	logic [LBA_W-1:0] start_q;
	logic [LBA_W-1:0] end_q;
	pec_tok_t         tok_q;
	pec_tok_t         tok_nxt;
	logic             is_load;
	logic             claim;
	logic             hit_ovl;
	logic             qhit;
	logic             do_clear;

	assign is_load  = tok_in.vld && (tok_in.op == OP_LOAD) && !tok_in.placed;
	// First free slot takes the new entry
	assign claim    = is_load && !occ_q;
	// Stored in-range entry meets the new used entry
	assign hit_ovl  = is_load && occ_q && tok_in.fl.used && flags_q.used && !flags_q.oor &&
		(tok_in.end_lba >= start_q) && (tok_in.entry_start <= end_q);
	assign qhit     = QRY_OK && tok_in.vld && (tok_in.op == OP_QUERY) && occ_q &&
		(tok_in.idx == MY_IDX);
	assign do_clear = tok_in.vld && (tok_in.op == OP_CLEAR);

	// Token update for the next cell
	always_comb begin
		tok_nxt = tok_in;
		if (hit_ovl) begin
			tok_nxt.fl.ovl = 1'b1;
		end
		if (claim) begin
			tok_nxt.placed = 1'b1;
			tok_nxt.idx    = MY_IDX;
		end
		if (qhit) begin
			tok_nxt.placed = 1'b1;
			tok_nxt.fl     = flags_q;
		end
	end

	// Slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= 1'b0;
			flags_q <= '0;
		end else if (do_clear) begin
			occ_q   <= 1'b0;
			flags_q <= '0;
		end else if (claim) begin
			occ_q   <= 1'b1;
			flags_q <= tok_in.fl;
		end else if (hit_ovl) begin
			flags_q.ovl <= 1'b1;
		end
	end

	// Stored bounds
	always_ff @(posedge clk) begin
		if (claim) begin
			start_q <= tok_in.entry_start;
			end_q   <= tok_in.end_lba;
		end
	end

	// Hand-off register to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the GPT partition entry checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pec_pkg::*;

	localparam int          LATENCY     = MAX_ENTRIES_DEF + 4;
	localparam int          ITEM_TARGET = 1450;
	localparam int          LONG_HOLD   = 700;
	localparam int unsigned CYCLE_LIMIT = 1_500_000;
	localparam int          PRINT_CAP   = 100;

	typedef enum {ROW_PREDICT, ROW_TYPED, ROW_WINDOW} row_kind_t;
	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;
	typedef enum {WIN_FULL, WIN_LOW, WIN_TOP, WIN_EMPTY, WIN_RANDOM, WIN_SINGLE} window_kind_t;

	// One request as the sender sees it
	typedef struct {
		pec_op_t          op;
		logic [63:0]      guid_hi;
		logic [63:0]      guid_lo;
		logic [63:0]      entry_start;
		logic [63:0]      end_lba;
		logic [63:0]      attr;
		logic [IDX_W-1:0] qidx;
	} entry_req_t;

	// Directed table row; a window row carries first/last in entry_start/end_lba
	typedef struct {
		row_kind_t  kind;
		entry_req_t rq;
		pec_res_t   res;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	pec_req_if req_bus ();
	pec_rsp_if rsp_bus ();

	partition_entry_checker uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_bus),
		.rsp     (rsp_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state: usable window and the entry table
	logic [63:0] win_first = FIRST_LBA_RST;
	logic [63:0] win_last  = LAST_LBA_RST;
	logic [63:0] slot_start [MAX_ENTRIES_DEF];
	logic [63:0] slot_end [MAX_ENTRIES_DEF];
	pec_flags_t  slot_fl [MAX_ENTRIES_DEF];
	int unsigned slot_count = 0;

	pec_res_t    status_q [$];
	dir_row_t    directed_rows [$];
	int          mismatch_count = 0;
	int          sent_count = 0;
	int          burst_left = 0;
	bit          gaps_on = 1'b1;
	bit          long_hold_req = 1'b0;
	rx_style_t   rx_style = RX_ALWAYS;
	int unsigned cycle_count = 0;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Expected status for one request; updates the predicted table
	function automatic pec_res_t predict_status(entry_req_t rq);
		pec_res_t   r;
		pec_flags_t f;
		r = '0;
		f = '0;
		case (rq.op)
			OP_CLEAR: begin
				foreach (slot_fl[k]) slot_fl[k] = '0;
				slot_count = 0;
			end
			OP_LOAD: begin
				if (slot_count >= MAX_ENTRIES_DEF) begin
					r.table_full = 1'b1;
				end else begin
					slot_start[slot_count] = rq.entry_start;
					slot_end[slot_count]   = rq.end_lba;
					if (|{rq.guid_hi, rq.guid_lo}) begin
						f.used = 1'b1;
						if (rq.entry_start > rq.end_lba || rq.entry_start < win_first ||
								rq.entry_start > win_last || rq.end_lba < win_first ||
								rq.end_lba > win_last)
							f.oor = 1'b1;
						else if (rq.attr[ATTR_OS_BIT])
							f.os = 1'b1;
						// new entry against every earlier used, in-range entry
						for (int k = 0; k < int'(slot_count); k++) begin
							if (slot_fl[k].used && !slot_fl[k].oor &&
									rq.end_lba >= slot_start[k] && rq.entry_start <= slot_end[k]) begin
								slot_fl[k].ovl = 1'b1;
								f.ovl = 1'b1;
							end
						end
					end
					slot_fl[slot_count] = f;
					r.entry_index = IDX_W'(slot_count);
					r.fl = f;
					slot_count++;
				end
			end
			OP_QUERY: begin
				r.entry_index = rq.qidx;
				if (rq.qidx < slot_count)
					r.fl = slot_fl[rq.qidx];
			end
			default: ;
		endcase
		r.usable = r.fl.used && !r.fl.oor && !r.fl.ovl && !r.fl.os;
		return r;
	endfunction

	function automatic void add_row(row_kind_t kind, pec_op_t op, logic [63:0] gh,
			logic [63:0] gl, logic [63:0] s, logic [63:0] e, logic [63:0] attr,
			logic [IDX_W-1:0] qi, pec_res_t res);
		dir_row_t row;
		row.kind           = kind;
		row.rq.op          = op;
		row.rq.guid_hi     = gh;
		row.rq.guid_lo     = gl;
		row.rq.entry_start = s;
		row.rq.end_lba     = e;
		row.rq.attr        = attr;
		row.rq.qidx        = qi;
		row.res            = res;
		directed_rows.push_back(row);
	endfunction

	// LBA near the window edges, inside it, or anywhere
	function automatic logic [63:0] random_lba();
		logic [63:0] span;
		span = win_last - win_first;
		case ($urandom_range(0, 9))
			0: return rand64();
			1: return win_first - 64'd1;
			2: return win_last + 64'd1;
			3: return win_first;
			4: return win_last;
			default: begin
				if (win_last < win_first)
					return win_first + $urandom_range(0, 64) - 64'd32;
				else if (&span)
					return rand64();
				else
					return win_first + rand64() % (span + 64'd1);
			end
		endcase
	endfunction

	function automatic entry_req_t random_request(bit fill);
		entry_req_t rq;
		int         pick;
		rq.guid_hi     = rand64();
		rq.guid_lo     = rand64();
		rq.attr        = rand64();
		rq.attr[ATTR_OS_BIT] = $urandom_range(0, 1);
		rq.entry_start = random_lba();
		pick = $urandom_range(0, 99);
		if (fill)
			rq.op = (pick < 95) ? OP_LOAD : OP_QUERY;
		else if (pick < 4)
			rq.op = OP_NONE;
		else if (pick < 7)
			rq.op = OP_CLEAR;
		else if (pick < 30)
			rq.op = OP_QUERY;
		else
			rq.op = OP_LOAD;
		// unused entries and one-sided GUIDs
		case ($urandom_range(0, 6))
			0, 1: begin
				rq.guid_hi = '0;
				rq.guid_lo = '0;
			end
			2: rq.guid_lo = '0;
			3: rq.guid_hi = '0;
			default: ;
		endcase
		// mostly short ranges so that entries collide
		case ($urandom_range(0, 7))
			0: rq.end_lba = random_lba();
			1: rq.end_lba = rq.entry_start - $urandom_range(1, 8);
			default: rq.end_lba = rq.entry_start + $urandom_range(0, 40);
		endcase
		if ($urandom_range(0, 3) != 0 && slot_count > 0)
			rq.qidx = IDX_W'($urandom_range(0, slot_count - 1));
		else
			rq.qidx = IDX_W'($urandom_range(0, 127));
		return rq;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] MISMATCH %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
	endtask

	// Offer one request from a falling edge; pace the sender in bursts afterwards
	task automatic transfer_entry(entry_req_t rq, bit use_typed, pec_res_t typed);
		pec_res_t want;
		int       gap;
		req_bus.valid          <= 1'b1;
		req_bus.operation      <= rq.op;
		req_bus.type_guid_high <= rq.guid_hi;
		req_bus.type_guid_low  <= rq.guid_lo;
		req_bus.entry_start    <= rq.entry_start;
		req_bus.end_lba        <= rq.end_lba;
		req_bus.attribute_bits <= rq.attr;
		req_bus.query_index    <= rq.qidx;
		do @(posedge clk); while (!req_bus.ready);
		want = predict_status(rq);
		status_q.push_back(use_typed ? typed : want);
		sent_count++;
		@(negedge clk);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on) begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 180) : $urandom_range(0, 12);
				if (gap > 0) begin
					req_bus.valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end
	endtask

	// Stop offering and wait for every expected result, then let the chain settle
	task automatic drain_results();
		req_bus.valid <= 1'b0;
		while (status_q.size() != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	task automatic write_window_reg(pec_reg_t sel, logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (sel == REG_FIRST_LBA)
			win_first = value;
		else
			win_last = value;
		@(negedge clk);
	endtask

	task automatic set_window(logic [63:0] first, logic [63:0] last);
		drain_results();
		write_window_reg(REG_FIRST_LBA, first);
		write_window_reg(REG_LAST_LBA, last);
	endtask

	// Result side: compare each transfer with the oldest expectation
	always @(posedge clk) begin
		pec_res_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (status_q.size() == 0) begin
				report_mismatch($sformatf("result with none expected, index %0d",
					rsp_bus.entry_index));
			end else begin
				want = status_q.pop_front();
				check_field("entry_index", 64'(rsp_bus.entry_index), 64'(want.entry_index));
				check_field("entry_used", 64'(rsp_bus.entry_used), 64'(want.fl.used));
				check_field("bounds_bad", 64'(rsp_bus.bounds_bad), 64'(want.fl.oor));
				check_field("overlap", 64'(rsp_bus.overlap), 64'(want.fl.ovl));
				check_field("os_reserved", 64'(rsp_bus.os_reserved), 64'(want.fl.os));
				check_field("usable", 64'(rsp_bus.usable), 64'(want.usable));
				check_field("table_full", 64'(rsp_bus.table_full), 64'(want.table_full));
			end
		end
	end

	// Receiver stalls, plus one long hold-off on request
	initial begin : rsp_pacer
		int hold_left;
		int tick;
		hold_left = 0;
		tick = 0;
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				case (rx_style)
					RX_RANDOM:  rsp_bus.ready <= ($urandom_range(0, 9) < 7);
					RX_PATTERN: rsp_bus.ready <= ((tick % 7) >= 3);
					default:    rsp_bus.ready <= 1'b1;
				endcase
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("partition_entry_checker test failed");
		$finish;
	end

	initial begin : stimulus
		entry_req_t   rq;
		window_kind_t wk;
		logic [63:0]  lo_b;
		logic [63:0]  hi_b;
		int           n_ops;
		int           phase;

		arst_n                 = 1'b0;
		req_bus.valid          = 1'b0;
		req_bus.operation      = OP_NONE;
		req_bus.type_guid_high = '0;
		req_bus.type_guid_low  = '0;
		req_bus.entry_start    = '0;
		req_bus.end_lba        = '0;
		req_bus.attribute_bits = '0;
		req_bus.query_index    = '0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;

		// Result layout: index, flags {used, oor, ovl, os}, usable, table_full
		// Reset window (34..0): every used entry is out of range
		add_row(ROW_TYPED, OP_QUERY, '0, '0, '0, '0, '0, 7'd0, {7'd0, 4'b0000, 2'b00});
		add_row(ROW_TYPED, OP_NONE, '1, '1, '1, '1, '1, 7'd127, {7'd0, 4'b0000, 2'b00});
		add_row(ROW_TYPED, OP_LOAD, '0, 64'd1, 64'd34, 64'd34, 64'd2, 7'd0,
			{7'd0, 4'b1100, 2'b00});
		add_row(ROW_TYPED, OP_QUERY, '0, '0, '0, '0, '0, 7'd0, {7'd0, 4'b1100, 2'b00});
		add_row(ROW_TYPED, OP_QUERY, '0, '0, '0, '0, '0, 7'd127, {7'd127, 4'b0000, 2'b00});
		add_row(ROW_TYPED, OP_CLEAR, '1, '1, '1, '1, '1, 7'd5, {7'd0, 4'b0000, 2'b00});
		// Widest window
		add_row(ROW_WINDOW, OP_NONE, '0, '0, '0, '1, '0, 7'd0, '0);
		add_row(ROW_TYPED, OP_LOAD, '1, '0, '0, '1, '0, 7'd0, {7'd0, 4'b1000, 2'b10});
		// unused entry still takes a slot
		add_row(ROW_TYPED, OP_LOAD, '0, '0, 64'd5, 64'd6, '1, 7'd0, {7'd1, 4'b0000, 2'b00});
		add_row(ROW_TYPED, OP_LOAD, '0, '1, 64'd10, 64'd20, 64'd2, 7'd0,
			{7'd2, 4'b1011, 2'b00});
		add_row(ROW_PREDICT, OP_QUERY, '0, '0, '0, '0, '0, 7'd0, '0);
		// reversed entry still marks overlap against the full-disk entry
		add_row(ROW_PREDICT, OP_LOAD, '0, 64'd1, 64'd50, 64'd40, '0, 7'd0, '0);
		add_row(ROW_PREDICT, OP_LOAD, 64'd1, '0, '1, '1, ~64'd2, 7'd0, '0);
		add_row(ROW_PREDICT, OP_QUERY, '0, '0, '0, '0, '0, 7'd1, '0);
		// Narrow window 100..200
		add_row(ROW_WINDOW, OP_NONE, '0, '0, 64'd100, 64'd200, '0, 7'd0, '0);
		add_row(ROW_TYPED, OP_CLEAR, '0, '0, '0, '0, '0, 7'd0, {7'd0, 4'b0000, 2'b00});
		add_row(ROW_PREDICT, OP_LOAD, '0, 64'd7, 64'd99, 64'd150, '0, 7'd0, '0);
		add_row(ROW_PREDICT, OP_LOAD, '0, 64'd7, 64'd150, 64'd201, '0, 7'd0, '0);
		add_row(ROW_PREDICT, OP_LOAD, '0, 64'd7, 64'd100, 64'd200, 64'd2, 7'd0, '0);
		add_row(ROW_PREDICT, OP_LOAD, '0, 64'd7, 64'd200, 64'd200, '0, 7'd0, '0);
		add_row(ROW_PREDICT, OP_LOAD, '0, 64'd7, 64'd201, 64'd99, '0, 7'd0, '0);
		add_row(ROW_PREDICT, OP_QUERY, '0, '0, '0, '0, '0, 7'd2, '0);

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WINDOW)
				set_window(directed_rows[i].rq.entry_start, directed_rows[i].rq.end_lba);
			else
				transfer_entry(directed_rows[i].rq, directed_rows[i].kind == ROW_TYPED,
					directed_rows[i].res);
		end

		// Random phases, each under its own window and pacing
		for (phase = 0; sent_count < ITEM_TARGET; phase++) begin
			wk = window_kind_t'(phase % 6);
			case (wk)
				WIN_FULL: begin
					lo_b = '0;
					hi_b = '1;
				end
				WIN_LOW: begin
					lo_b = $urandom_range(0, 1000);
					hi_b = lo_b + $urandom_range(200, 3000);
				end
				WIN_TOP: begin
					lo_b = 64'hFFFF_FFFF_FFFF_FFFF - 64'd2000;
					hi_b = '1;
				end
				WIN_EMPTY: begin
					lo_b = FIRST_LBA_RST;
					hi_b = LAST_LBA_RST;
				end
				WIN_RANDOM: begin
					lo_b = rand64();
					hi_b = lo_b + $urandom_range(100, 5000);
					if (hi_b < lo_b)
						hi_b = '1;
				end
				default: begin
					lo_b = $urandom_range(0, 500);
					hi_b = lo_b;
				end
			endcase
			set_window(lo_b, hi_b);
			rx_style = rx_style_t'(phase % 3);
			gaps_on  = (phase % 4 != 1);
			if (phase == 1)
				long_hold_req = 1'b1;

			rq = random_request(1'b0);
			rq.op = OP_CLEAR;
			transfer_entry(rq, 1'b0, '0);

			// two phases run the table past full
			n_ops = (phase == 2 || phase == 7) ? 150 : $urandom_range(30, 80);
			for (int i = 0; i < n_ops; i++) begin
				if (phase == 3 && i == n_ops / 2)
					drain_results();
				transfer_entry(random_request(phase == 2 || phase == 7), 1'b0, '0);
			end
		end

		drain_results();
		if (mismatch_count == 0)
			$display("partition_entry_checker test passed");
		else
			$display("partition_entry_checker test failed");
		$finish;
	end

endmodule
